@@ hw/rtl/cohc_pkg.sv @@
// ----------------------------------------------------------------------------
// cohc_pkg
// Shared types and constants of the compare operand hint collector.
// ----------------------------------------------------------------------------
`default_nettype none

package cohc_pkg;

  localparam logic [63:0] HASH_C1 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_C2 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_C3 = 64'h94d049bb133111eb;
  localparam logic [63:0] HASH_C4 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_C5 = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] CFG_BLOOM_ENABLE = 2'd0;
  localparam logic [1:0] CFG_BLOOM_PERIOD = 2'd1;
  localparam logic [1:0] CFG_MAX_RECORDS  = 2'd2;

  typedef enum logic [2:0] {
    OC_LIMIT,
    OC_NOT_CONST,
    OC_FILTERED,
    OC_SEEN,
    OC_REFRESH,
    OC_APPEND,
    OC_EVICT
  } outcome_t;

  typedef enum logic [4:0] {
    S_SWEEP_INIT,
    S_IDLE,
    S_CALL,
    S_BCLR,
    S_CHECK,
    S_ROW,
    S_OP,
    S_M1,
    S_M1W,
    S_M2,
    S_M2W,
    S_BRD,
    S_BWR1,
    S_BWR2,
    S_PCMP,
    S_PUPD,
    S_NEXT,
    S_WB,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     call;
    logic     sweep;
    logic     sweep_pools;
    logic     check;
    logic     row_load;
    logic     mul_second;
    logic     bloom_rd;
    logic     bloom_wr1;
    logic     bloom_wr2;
    logic     pool_cmp;
    logic     pool_upd;
    logic     next_op;
    logic     writeback;
    logic     out_load;
    logic     oc_wr;
    logic     oc_both;
    outcome_t oc_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bclr_need;
    logic sweep_last;
    logic active;
    logic is_const;
    logic filtered;
    logic bloom_en;
    logic seen;
    logic op_b;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/cohc_mul64.sv @@
// ----------------------------------------------------------------------------
// cohc_mul64
// Two-stage low-half 64x64 multiplier built from three 32x32 products.
// ----------------------------------------------------------------------------
`default_nettype none

module cohc_mul64 (
  input  wire logic        clk,
  input  wire logic [63:0] a,
  input  wire logic [63:0] c,
  output logic      [63:0] p
);

  logic [63:0] pp0_r;
  logic [31:0] pp1_r;
  logic [31:0] pp2_r;
  logic [63:0] p_r;
  logic [63:0] pp0;
  logic [31:0] pp1;
  logic [31:0] pp2;

  assign pp0 = a[31:0] * c[31:0];
  assign pp1 = a[63:32] * c[31:0];
  assign pp2 = a[31:0] * c[63:32];

  always_ff @(posedge clk) begin
    pp0_r <= pp0;
    pp1_r <= pp1;
    pp2_r <= pp2;
    p_r   <= pp0_r + {pp1_r + pp2_r, 32'd0};
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ hw/rtl/cohc_ctrl.sv @@
// ----------------------------------------------------------------------------
// cohc_ctrl
// Sequencer: call handling, per-operand hash, bloom and pool steps.
// ----------------------------------------------------------------------------
`default_nettype none

module cohc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cohc_pkg::ctrl_sts_t sts,
  output cohc_pkg::ctrl_cmd_t      cmd
);

  import cohc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP_INIT: if (sts.sweep_last) state_nxt = S_IDLE;
      S_IDLE:       if (in_valid) state_nxt = S_CALL;
      S_CALL:       state_nxt = sts.bclr_need ? S_BCLR : S_CHECK;
      S_BCLR:       if (sts.sweep_last) state_nxt = S_CHECK;
      S_CHECK:      state_nxt = S_ROW;
      S_ROW: begin
        if (!sts.active || !sts.is_const) state_nxt = S_DONE;
        else state_nxt = S_OP;
      end
      S_OP: begin
        if (sts.filtered) state_nxt = S_NEXT;
        else if (sts.bloom_en) state_nxt = S_M1;
        else state_nxt = S_PCMP;
      end
      S_M1:   state_nxt = S_M1W;
      S_M1W:  state_nxt = S_M2;
      S_M2:   state_nxt = S_M2W;
      S_M2W:  state_nxt = S_BRD;
      S_BRD:  state_nxt = S_BWR1;
      S_BWR1: state_nxt = S_BWR2;
      S_BWR2: state_nxt = sts.seen ? S_NEXT : S_PCMP;
      S_PCMP: state_nxt = S_PUPD;
      S_PUPD: state_nxt = S_NEXT;
      S_NEXT: state_nxt = sts.op_b ? S_WB : S_OP;
      S_WB:   state_nxt = S_DONE;
      S_DONE: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.oc_code = OC_LIMIT;
    unique case (state_r)
      S_SWEEP_INIT: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_pools = 1'b1;
      end
      S_IDLE:  cmd.load_in = in_valid;
      S_CALL:  cmd.call = 1'b1;
      S_BCLR:  cmd.sweep = 1'b1;
      S_CHECK: cmd.check = 1'b1;
      S_ROW: begin
        cmd.row_load = 1'b1;
        if (sts.active && !sts.is_const) begin
          cmd.oc_wr   = 1'b1;
          cmd.oc_both = 1'b1;
          cmd.oc_code = OC_NOT_CONST;
        end
      end
      S_OP: begin
        if (sts.filtered) begin
          cmd.oc_wr   = 1'b1;
          cmd.oc_code = OC_FILTERED;
        end
      end
      S_M1, S_M1W, S_M2W: ;
      S_M2:   cmd.mul_second = 1'b1;
      S_BRD:  cmd.bloom_rd = 1'b1;
      S_BWR1: cmd.bloom_wr1 = 1'b1;
      S_BWR2: begin
        cmd.bloom_wr2 = 1'b1;
        if (sts.seen) begin
          cmd.oc_wr   = 1'b1;
          cmd.oc_code = OC_SEEN;
        end
      end
      S_PCMP: cmd.pool_cmp = 1'b1;
      S_PUPD: cmd.pool_upd = 1'b1;
      S_NEXT: cmd.next_op = !sts.op_b;
      S_WB:   cmd.writeback = 1'b1;
      S_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_SWEEP_INIT |=> state_r != S_SWEEP_INIT)
    else $error("reset sweep entered again");

  a_accept_call: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_CALL)
    else $error("accepted word not started");

  a_hash_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_M1 |-> sts.bloom_en)
    else $error("hash run with filter off");

endmodule

`default_nettype wire

@@ hw/rtl/cohc_datapath.sv @@
// ----------------------------------------------------------------------------
// cohc_datapath
// Input word, config and counters, hash units, bloom store and pool tables.
// ----------------------------------------------------------------------------
`default_nettype none

module cohc_datapath #(
  parameter int NUM_POOLS    = 64,
  parameter int POOL_ENTRIES = 16,
  parameter int BLOOM_BITS   = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cohc_pkg::ctrl_cmd_t cmd,
  output cohc_pkg::ctrl_sts_t      sts,
  input  wire logic                in_first_of_call,
  input  wire logic [5:0]          in_pool_index,
  input  wire logic                in_const_flag,
  input  wire logic [1:0]          in_size_code,
  input  wire logic [63:0]         in_operand_a,
  input  wire logic [63:0]         in_operand_b,
  input  wire logic [63:0]         in_site_address,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [2:0]               out_outcome_a,
  output logic [3:0]               out_slot_a,
  output logic [2:0]               out_outcome_b,
  output logic [3:0]               out_slot_b,
  output logic [4:0]               out_pool_fill
);

  import cohc_pkg::*;

  localparam int SLOT_W     = $clog2(POOL_ENTRIES);
  localparam int CNT_W      = $clog2(POOL_ENTRIES + 1);
  localparam int POOL_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int IDX_W      = $clog2(BLOOM_BITS);
  localparam int BLOOM_ROWS = BLOOM_BITS / 64;
  localparam int ROW_W      = (BLOOM_ROWS > 1) ? $clog2(BLOOM_ROWS) : 1;
  localparam int SWEEP_N    = (NUM_POOLS > BLOOM_ROWS) ? NUM_POOLS : BLOOM_ROWS;
  localparam int SW_W       = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;
  localparam int PE2        = 1 << SLOT_W;

  // input word
  logic        first_r;
  logic [5:0]  pool_r;
  logic        const_r;
  logic [1:0]  code_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] site_r;

  // config and counters
  logic        bloom_en_r;
  logic [15:0] period_r;
  logic [15:0] maxrec_r;
  logic [15:0] cc_r;
  logic [15:0] rec_r;
  logic [15:0] cc_inc;
  logic        bclr_need;

  logic [SW_W-1:0] sw_cnt_r;
  logic            sweep_last;

  logic        in_range;
  logic        active_r;
  logic        inrange_r;
  logic        op_b_r;
  logic [63:0] cur;
  logic        filtered;

  outcome_t       oa_r;
  outcome_t       ob_r;
  logic [3:0]     sa_r;
  logic [3:0]     sb_r;

  logic           out_valid_r;
  logic [2:0]     out_oa_r;
  logic [2:0]     out_ob_r;
  logic [3:0]     out_sa_r;
  logic [3:0]     out_sb_r;
  logic [4:0]     out_fill_r;

  // hash
  logic [63:0] mul_a_in;
  logic [63:0] mul_a_c;
  logic [63:0] mul_b_in;
  logic [63:0] mul_b_c;
  logic [63:0] mul_a_p;
  logic [63:0] mul_b_p;
  logic [63:0] x1_pre;
  logic [63:0] x1;
  logic [63:0] x2_pre;
  logic [63:0] x2;
  logic [63:0] y1;
  logic [63:0] y2;
  logic [IDX_W-1:0] hidx1_r;
  logic [IDX_W-1:0] hidx2_r;

  // bloom store
  logic [63:0]      bloom_mem [BLOOM_ROWS];
  logic [63:0]      brd1_r;
  logic [63:0]      brd2_r;
  logic [ROW_W-1:0] h1_row;
  logic [ROW_W-1:0] h2_row;
  logic [ROW_W-1:0] r1_row;
  logic [ROW_W-1:0] r2_row;
  logic [63:0]      m1;
  logic [63:0]      m2;
  logic             same_row;
  logic             seen_r;
  logic             b_we;
  logic [ROW_W-1:0] b_waddr;
  logic [63:0]      b_wdata;

  // pool tables
  logic [POOL_ENTRIES-1:0][63:0] pval_mem   [NUM_POOLS];
  logic [POOL_ENTRIES-1:0][63:0] psite_mem  [NUM_POOLS];
  logic [POOL_ENTRIES-1:0][1:0]  pcode_mem  [NUM_POOLS];
  logic [POOL_ENTRIES-1:0][31:0] pstamp_mem [NUM_POOLS];
  logic [CNT_W-1:0]              pcnt_mem   [NUM_POOLS];
  logic [31:0]                   pgen_mem   [NUM_POOLS];

  logic [POOL_ENTRIES-1:0][63:0] pval_rd_r;
  logic [POOL_ENTRIES-1:0][63:0] psite_rd_r;
  logic [POOL_ENTRIES-1:0][1:0]  pcode_rd_r;
  logic [POOL_ENTRIES-1:0][31:0] pstamp_rd_r;
  logic [CNT_W-1:0]              pcnt_rd_r;
  logic [31:0]                   pgen_rd_r;

  logic [POOL_ENTRIES-1:0][63:0] rval_r;
  logic [POOL_ENTRIES-1:0][63:0] rsite_r;
  logic [POOL_ENTRIES-1:0][1:0]  rcode_r;
  logic [POOL_ENTRIES-1:0][31:0] rstamp_r;
  logic [CNT_W-1:0]              rcnt_r;
  logic [31:0]                   rgen_r;

  logic [POOL_W-1:0] pool_addr;
  logic [POOL_W-1:0] sw_paddr;
  logic [ROW_W-1:0]  sw_baddr;

  logic [POOL_ENTRIES-1:0] hitv;
  logic                    hit_any;
  logic [SLOT_W-1:0]       hit_idx;
  logic [31:0]             tst [2*PE2];
  logic [SLOT_W-1:0]       tix [2*PE2];
  logic                    hit_r;
  logic [SLOT_W-1:0]       hit_idx_r;
  logic [SLOT_W-1:0]       vic_r;

  logic [31:0]       stamp;
  logic [SLOT_W-1:0] widx;
  outcome_t          upd_oc;

  // ---- input word, config, counters
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      first_r <= in_first_of_call;
      pool_r  <= in_pool_index;
      const_r <= in_const_flag;
      code_r  <= in_size_code;
      a_r     <= in_operand_a;
      b_r     <= in_operand_b;
      site_r  <= in_site_address;
    end
  end

  assign cc_inc    = cc_r + 16'd1;
  assign bclr_need = first_r && bloom_en_r && (cc_inc >= period_r);
  assign in_range  = (32'(pool_r) < NUM_POOLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bloom_en_r <= 1'b1;
      period_r   <= 16'd1024;
      maxrec_r   <= 16'd4096;
      cc_r       <= '0;
      rec_r      <= '0;
      sw_cnt_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BLOOM_ENABLE: bloom_en_r <= cfg_data[0];
          CFG_BLOOM_PERIOD: period_r <= cfg_data;
          CFG_MAX_RECORDS:  maxrec_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.call && first_r) begin
        rec_r <= '0;
        if (bloom_en_r) cc_r <= bclr_need ? 16'd0 : cc_inc;
      end
      if (cmd.check && in_range && (rec_r < maxrec_r)) rec_r <= rec_r + 16'd1;
      if (cmd.sweep) sw_cnt_r <= sweep_last ? '0 : sw_cnt_r + SW_W'(1);
    end
  end

  assign sweep_last = cmd.sweep_pools ? (32'(sw_cnt_r) == SWEEP_N - 1)
                                      : (32'(sw_cnt_r) == BLOOM_ROWS - 1);

  assign cur      = op_b_r ? b_r : a_r;
  assign filtered = (cur[63:2] == 62'd0) || (&cur);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      inrange_r <= in_range;
      active_r  <= in_range && (rec_r < maxrec_r);
    end
    if (cmd.row_load) op_b_r <= 1'b0;
    else if (cmd.next_op) op_b_r <= 1'b1;
  end

  // ---- hashing
  assign x1_pre = site_r ^ mul_a_p ^ (64'd1 << (6'd13 + 6'(code_r)));
  assign x1     = x1_pre ^ (x1_pre >> 32);
  assign x2_pre = cur ^ mul_b_p ^ (HASH_C4 << code_r);
  assign x2     = x2_pre ^ (x2_pre >> 30);

  assign mul_a_in = cmd.mul_second ? x1 : cur;
  assign mul_a_c  = cmd.mul_second ? HASH_C2 : HASH_C1;
  assign mul_b_in = cmd.mul_second ? x2 : site_r;
  assign mul_b_c  = cmd.mul_second ? HASH_C5 : HASH_C3;

  cohc_mul64 u_mul_a (.clk(clk), .a(mul_a_in), .c(mul_a_c), .p(mul_a_p));
  cohc_mul64 u_mul_b (.clk(clk), .a(mul_b_in), .c(mul_b_c), .p(mul_b_p));

  assign y1 = mul_a_p ^ (mul_a_p >> 27);
  assign y2 = mul_b_p ^ (mul_b_p >> 31);

  assign h1_row   = ROW_W'(y1[IDX_W-1:0] >> 6);
  assign h2_row   = ROW_W'(y2[IDX_W-1:0] >> 6);
  assign r1_row   = ROW_W'(hidx1_r >> 6);
  assign r2_row   = ROW_W'(hidx2_r >> 6);
  assign m1       = 64'd1 << hidx1_r[5:0];
  assign m2       = 64'd1 << hidx2_r[5:0];
  assign same_row = (r1_row == r2_row);
  assign sw_baddr = ROW_W'(sw_cnt_r);
  assign sw_paddr = POOL_W'(sw_cnt_r);

  always_comb begin
    b_we    = 1'b0;
    b_waddr = r1_row;
    b_wdata = brd1_r | m1 | (same_row ? m2 : 64'd0);
    if (cmd.sweep) begin
      b_we    = (32'(sw_cnt_r) < BLOOM_ROWS);
      b_waddr = sw_baddr;
      b_wdata = '0;
    end else if (cmd.bloom_wr1) begin
      b_we = 1'b1;
    end else if (cmd.bloom_wr2) begin
      b_we    = 1'b1;
      b_waddr = r2_row;
      b_wdata = brd2_r | m2 | (same_row ? m1 : 64'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) bloom_mem[b_waddr] <= b_wdata;
    if (cmd.bloom_rd) begin
      brd1_r  <= bloom_mem[h1_row];
      brd2_r  <= bloom_mem[h2_row];
      hidx1_r <= y1[IDX_W-1:0];
      hidx2_r <= y2[IDX_W-1:0];
    end
    if (cmd.bloom_wr1) seen_r <= brd1_r[hidx1_r[5:0]] && brd2_r[hidx2_r[5:0]];
  end

  // ---- pool tables
  assign pool_addr = POOL_W'(pool_r);

  always_ff @(posedge clk) begin
    if (cmd.sweep && cmd.sweep_pools && (32'(sw_cnt_r) < NUM_POOLS)) begin
      pcnt_mem[sw_paddr] <= '0;
      pgen_mem[sw_paddr] <= '0;
    end else if (cmd.writeback && active_r && const_r) begin
      pval_mem[pool_addr]   <= rval_r;
      psite_mem[pool_addr]  <= rsite_r;
      pcode_mem[pool_addr]  <= rcode_r;
      pstamp_mem[pool_addr] <= rstamp_r;
      pcnt_mem[pool_addr]   <= rcnt_r;
      pgen_mem[pool_addr]   <= rgen_r;
    end
    if (cmd.check && in_range) begin
      pval_rd_r   <= pval_mem[pool_addr];
      psite_rd_r  <= psite_mem[pool_addr];
      pcode_rd_r  <= pcode_mem[pool_addr];
      pstamp_rd_r <= pstamp_mem[pool_addr];
      pcnt_rd_r   <= pcnt_mem[pool_addr];
      pgen_rd_r   <= pgen_mem[pool_addr];
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      hitv[i] = (i < 32'(rcnt_r)) && (rval_r[i] == cur) &&
                (rsite_r[i] == site_r) && (rcode_r[i] == code_r);
    end
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (hitv[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // lowest stamp, left side wins ties
  always_comb begin
    for (int i = 0; i < 2 * PE2; i++) begin
      tst[i] = '1;
      tix[i] = '0;
    end
    for (int i = 0; i < PE2; i++) begin
      tix[PE2+i] = SLOT_W'(i);
      if (i < POOL_ENTRIES) tst[PE2+i] = rstamp_r[i];
    end
    for (int n = PE2 - 1; n >= 1; n--) begin
      if (tst[2*n+1] < tst[2*n]) begin
        tst[n] = tst[2*n+1];
        tix[n] = tix[2*n+1];
      end else begin
        tst[n] = tst[2*n];
        tix[n] = tix[2*n];
      end
    end
  end

  assign stamp = rgen_r + 32'd1;

  always_comb begin
    if (hit_r) begin
      widx   = hit_idx_r;
      upd_oc = OC_REFRESH;
    end else if (32'(rcnt_r) < POOL_ENTRIES) begin
      widx   = SLOT_W'(rcnt_r);
      upd_oc = OC_APPEND;
    end else begin
      widx   = vic_r;
      upd_oc = OC_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      rval_r   <= pval_rd_r;
      rsite_r  <= psite_rd_r;
      rcode_r  <= pcode_rd_r;
      rstamp_r <= pstamp_rd_r;
      rcnt_r   <= pcnt_rd_r;
      rgen_r   <= pgen_rd_r;
    end
    if (cmd.pool_cmp) begin
      hit_r     <= hit_any;
      hit_idx_r <= hit_idx;
      vic_r     <= tix[1];
    end
    if (cmd.pool_upd) begin
      rgen_r         <= stamp;
      rstamp_r[widx] <= stamp;
      if (!hit_r) begin
        rval_r[widx]  <= cur;
        rsite_r[widx] <= site_r;
        rcode_r[widx] <= code_r;
        if (upd_oc == OC_APPEND) rcnt_r <= rcnt_r + CNT_W'(1);
      end
    end
  end

  // ---- outcomes and output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      oa_r <= OC_LIMIT;
      ob_r <= OC_LIMIT;
      sa_r <= '0;
      sb_r <= '0;
    end else if (cmd.oc_wr) begin
      if (cmd.oc_both || !op_b_r) oa_r <= cmd.oc_code;
      if (cmd.oc_both || op_b_r) ob_r <= cmd.oc_code;
    end else if (cmd.pool_upd) begin
      if (op_b_r) begin
        ob_r <= upd_oc;
        sb_r <= 4'(widx);
      end else begin
        oa_r <= upd_oc;
        sa_r <= 4'(widx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_oa_r   <= oa_r;
      out_ob_r   <= ob_r;
      out_sa_r   <= sa_r;
      out_sb_r   <= sb_r;
      out_fill_r <= inrange_r ? 5'(rcnt_r) : 5'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_outcome_a = out_oa_r;
  assign out_outcome_b = out_ob_r;
  assign out_slot_a    = out_sa_r;
  assign out_slot_b    = out_sb_r;
  assign out_pool_fill = out_fill_r;

  always_comb begin
    sts.bclr_need  = bclr_need;
    sts.sweep_last = sweep_last;
    sts.active     = active_r;
    sts.is_const   = const_r;
    sts.filtered   = filtered;
    sts.bloom_en   = bloom_en_r;
    sts.seen       = seen_r;
    sts.op_b       = op_b_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

@@ hw/rtl/compare_operand_hint_collector.sv @@
// ----------------------------------------------------------------------------
// compare_operand_hint_collector
// Comparison operand collector with a bloom seen-filter and dedup pools.
//
// Input channel (in_*): one comparison record per word, valid/ready.
// Output channel (out_*): one result word per record, valid/ready.
// Config channel (cfg_*): index 0 bloom enable, 1 bloom clear period,
// 2 per-call record limit; always ready. It is to be written while idle
// by the user; the block itself does not enforce it. One record is in
// work at a time. A record that is not constant, over the call limit or
// with a pool index out of range skips the operand steps. Each operand
// that is not filtered runs, with the filter on, the two dependent 64-bit
// multiplies of each hash chain (two-stage units) and a bloom read-
// modify-write; it then takes the pool compare and update unless the
// bloom hit. A bloom clear at the start of a call clears one row a
// cycle. After reset a clearing pass empties the bloom store and pool
// counts; in_ready stays low meanwhile. A stalled receiver keeps the
// result word in the output register; the next record is still taken and
// waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_operand_hint_collector #(
  parameter int NUM_POOLS    = 64,
  parameter int POOL_ENTRIES = 16,
  parameter int BLOOM_BITS   = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_first_of_call,
  input  wire logic [5:0]  in_pool_index,
  input  wire logic        in_const_flag,
  input  wire logic [1:0]  in_size_code,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic [63:0] in_site_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_outcome_a,
  output logic [3:0]       out_slot_a,
  output logic [2:0]       out_outcome_b,
  output logic [3:0]       out_slot_b,
  output logic [4:0]       out_pool_fill,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import cohc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  cohc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  cohc_datapath #(
    .NUM_POOLS   (NUM_POOLS),
    .POOL_ENTRIES(POOL_ENTRIES),
    .BLOOM_BITS  (BLOOM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_first_of_call(in_first_of_call),
    .in_pool_index   (in_pool_index),
    .in_const_flag   (in_const_flag),
    .in_size_code    (in_size_code),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .in_site_address (in_site_address),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_outcome_a   (out_outcome_a),
    .out_slot_a      (out_slot_a),
    .out_outcome_b   (out_outcome_b),
    .out_slot_b      (out_slot_b),
    .out_pool_fill   (out_pool_fill)
  );

endmodule

`default_nettype wire

@@ tb/cohc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cohc_checker
// Watches the record, result and register channels of the hint collector,
// keeps its own copy of the bloom store and pools, predicts each result
// word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module cohc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_first_of_call,
  input  wire logic [5:0]  in_pool_index,
  input  wire logic        in_const_flag,
  input  wire logic [1:0]  in_size_code,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic [63:0] in_site_address,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_outcome_a,
  input  wire logic [3:0]  out_slot_a,
  input  wire logic [2:0]  out_outcome_b,
  input  wire logic [3:0]  out_slot_b,
  input  wire logic [4:0]  out_pool_fill,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               errors,
  output int               pending
);

  import cohc_pkg::*;

  localparam int POOLS   = 64;
  localparam int ENTRIES = 16;
  localparam int BITS    = 4096;

  typedef struct packed {
    outcome_t   oc_a;
    logic [3:0] slot_a;
    outcome_t   oc_b;
    logic [3:0] slot_b;
    logic [4:0] fill;
  } hint_word_t;

  hint_word_t  hint_q[$];

  logic [63:0] ent_val   [POOLS*ENTRIES];
  logic [63:0] ent_site  [POOLS*ENTRIES];
  logic [1:0]  ent_code  [POOLS*ENTRIES];
  logic [31:0] ent_stamp [POOLS*ENTRIES];
  int          pool_cnt  [POOLS];
  logic [31:0] pool_gen  [POOLS];
  logic        seen_bits [BITS];
  logic [15:0] call_cnt;
  int          rec_cnt;
  logic        bloom_on;
  logic [15:0] clear_period;
  logic [15:0] rec_limit;

  task automatic report(string what, int got, int want);
    $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [11:0] hash_a(logic [63:0] site, logic [63:0] v, logic [63:0] sz);
    logic [63:0] x;
    x = site ^ (v * HASH_C1) ^ (sz << 13);
    x ^= x >> 32;
    x = x * HASH_C2;
    x ^= x >> 27;
    return x[11:0];
  endfunction

  function automatic logic [11:0] hash_b(logic [63:0] site, logic [63:0] v, logic [63:0] sz);
    logic [63:0] x;
    x = v ^ (site * HASH_C3) ^ (sz * HASH_C4);
    x ^= x >> 30;
    x = x * HASH_C5;
    x ^= x >> 31;
    return x[11:0];
  endfunction

  task automatic collect_operand(int p, logic [63:0] site, logic [63:0] v, logic [1:0] code,
                                 output outcome_t oc, output logic [3:0] slot);
    logic [63:0] sz;
    logic [11:0] i1, i2;
    logic        hit;
    int          base, n, victim;
    logic [31:0] stamp;
    slot = '0;
    if ((v & ~64'd3) == 64'd0 || v == '1) begin
      oc = OC_FILTERED;
      return;
    end
    if (bloom_on) begin
      sz  = 64'd1 << code;
      i1  = hash_a(site, v, sz);
      i2  = hash_b(site, v, sz);
      hit = seen_bits[i1] && seen_bits[i2];
      seen_bits[i1] = 1'b1;
      seen_bits[i2] = 1'b1;
      if (hit) begin
        oc = OC_SEEN;
        return;
      end
    end
    base = p * ENTRIES;
    n = pool_cnt[p];
    pool_gen[p] = pool_gen[p] + 32'd1;
    stamp = pool_gen[p];
    for (int i = 0; i < n; i++) begin
      if (ent_val[base+i] == v && ent_site[base+i] == site && ent_code[base+i] == code) begin
        ent_stamp[base+i] = stamp;
        slot = i[3:0];
        oc = OC_REFRESH;
        return;
      end
    end
    if (n < ENTRIES) begin
      victim = n;
      pool_cnt[p] = n + 1;
      oc = OC_APPEND;
    end else begin
      victim = 0;
      for (int i = 1; i < ENTRIES; i++)
        if (ent_stamp[base+i] < ent_stamp[base+victim]) victim = i;
      oc = OC_EVICT;
    end
    ent_val[base+victim]   = v;
    ent_site[base+victim]  = site;
    ent_code[base+victim]  = code;
    ent_stamp[base+victim] = stamp;
    slot = victim[3:0];
  endtask

  task automatic predict_record();
    hint_word_t w;
    int p;
    p = in_pool_index;
    w = '{OC_LIMIT, 4'd0, OC_LIMIT, 4'd0, 5'd0};
    if (in_first_of_call) begin
      rec_cnt = 0;
      if (bloom_on) begin
        call_cnt = call_cnt + 16'd1;
        if (call_cnt >= clear_period) begin
          foreach (seen_bits[i]) seen_bits[i] = 1'b0;
          call_cnt = '0;
        end
      end
    end
    if (rec_cnt < rec_limit) begin
      rec_cnt++;
      if (!in_const_flag) begin
        w.oc_a = OC_NOT_CONST;
        w.oc_b = OC_NOT_CONST;
      end else begin
        collect_operand(p, in_site_address, in_operand_a, in_size_code, w.oc_a, w.slot_a);
        collect_operand(p, in_site_address, in_operand_b, in_size_code, w.oc_b, w.slot_b);
      end
    end
    w.fill = pool_cnt[p][4:0];
    hint_q.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hint_q.delete();
      foreach (pool_cnt[i]) pool_cnt[i] = 0;
      foreach (pool_gen[i]) pool_gen[i] = '0;
      foreach (seen_bits[i]) seen_bits[i] = 1'b0;
      call_cnt     = '0;
      rec_cnt      = 0;
      bloom_on     = 1'b1;
      clear_period = 16'd1024;
      rec_limit    = 16'd4096;
      errors       = 0;
      pending      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOOM_ENABLE: bloom_on     = cfg_data[0];
          CFG_BLOOM_PERIOD: clear_period = cfg_data;
          CFG_MAX_RECORDS:  rec_limit    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        hint_word_t w;
        if (hint_q.size() == 0) begin
          report("unexpected word", out_outcome_a, -1);
        end else begin
          w = hint_q.pop_front();
          if (out_outcome_a !== w.oc_a)   report("outcome_a", out_outcome_a, w.oc_a);
          if (out_slot_a    !== w.slot_a) report("slot_a", out_slot_a, w.slot_a);
          if (out_outcome_b !== w.oc_b)   report("outcome_b", out_outcome_b, w.oc_b);
          if (out_slot_b    !== w.slot_b) report("slot_b", out_slot_b, w.slot_b);
          if (out_pool_fill !== w.fill)   report("pool_fill", out_pool_fill, w.fill);
        end
      end
      if (in_valid && in_ready) predict_record();
      pending = hint_q.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives records and register writes into the hint collector under
// several idling patterns; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cohc_pkg::*;

  localparam int LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_first_of_call = 1'b0;
  logic [5:0]  in_pool_index = '0;
  logic        in_const_flag = 1'b0;
  logic [1:0]  in_size_code = '0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic [63:0] in_site_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_outcome_a;
  logic [3:0]  out_slot_a;
  logic [2:0]  out_outcome_b;
  logic [3:0]  out_slot_b;
  logic [4:0]  out_pool_fill;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  always #6 clk = ~clk;

  compare_operand_hint_collector u_top (.*);

  cohc_checker u_chk (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send(logic first, logic [5:0] p, logic cst, logic [1:0] code,
                      logic [63:0] a, logic [63:0] b, logic [63:0] site);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_first_of_call <= first;
    in_pool_index    <= p;
    in_const_flag    <= cst;
    in_size_code     <= code;
    in_operand_a     <= a;
    in_operand_b     <= b;
    in_site_address  <= site;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic en, logic [15:0] period, logic [15:0] lim);
    cfg_write(CFG_BLOOM_ENABLE, {15'd0, en});
    cfg_write(CFG_BLOOM_PERIOD, period);
    cfg_write(CFG_MAX_RECORDS, lim);
  endtask

  function automatic logic [63:0] pick_val();
    case ($urandom_range(0, 9))
      0:       return 64'($urandom_range(0, 3));
      1:       return '1;
      2, 3, 4: return 64'h100 + 64'($urandom_range(0, 7));
      5:       return {$urandom, $urandom} | 64'h4;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_record();
    logic [63:0] site;
    logic [5:0]  p;
    site = ($urandom_range(0, 9) < 7) ? 64'hffff_0000_0000_1000 + 64'($urandom_range(0, 3))
                                      : {$urandom, $urandom};
    p = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
    send($urandom_range(0, 7) == 0, p, $urandom_range(0, 9) != 0, 2'($urandom_range(0, 3)),
         pick_val(), pick_val(), site);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(1'b1, 16'd1024, 16'd4096);

    send(1, 6'd0, 0, 2'd0, 64'h1234, 64'h5678, 64'h10);
    send(0, 6'd0, 1, 2'd1, 64'd0, 64'd3, 64'h10);
    send(0, 6'd0, 1, 2'd2, '1, 64'd4, 64'h10);
    send(0, 6'd0, 1, 2'd2, 64'd5, 64'd4, 64'h10);
    send(0, 6'd63, 1, 2'd3, 64'h8000_0000_0000_0000, 64'haaaa_5555_aaaa_5555, '1);
    cfg_write(CFG_BLOOM_ENABLE, 16'd0);
    for (int i = 0; i < 9; i++)
      send(0, 6'd1, 1, 2'(i), 64'd16 + 64'(2 * i), 64'd17 + 64'(2 * i), 64'h20);
    send(0, 6'd1, 1, 2'd1, 64'd32, 64'd33, 64'h20);
    cfg_write(CFG_MAX_RECORDS, 16'd1);
    send(1, 6'd2, 1, 2'd0, 64'h40, 64'h41, 64'h30);
    send(0, 6'd2, 1, 2'd0, 64'h42, 64'h43, 64'h30);
    set_regs(1'b1, 16'd1, 16'd65535);
    send(1, 6'd3, 1, 2'd0, 64'h50, 64'h50, 64'h30);
    send(1, 6'd3, 1, 2'd0, 64'h50, 64'h51, 64'h30);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(1'b1, 16'd1024, 16'd4096);
        1: set_regs(1'b0, 16'd1, 16'd1);
        2: set_regs(1'b1, 16'd1, 16'd65535);
        3: set_regs(1'b1, 16'd65535, 16'd3);
        4: set_regs(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
        default: set_regs(1'b0, 16'd2, 16'd65535);
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 48; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 48; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      repeat (250) random_record();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
